// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and constants of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    localparam int MAX_BLOCKS_DEF = 1024;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    localparam logic [OP_W-1:0] OP_OCCUPY = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;   // write one word of the clearing pass
        logic take;       // capture request, start the first map read
        logic commit;     // finish occupy/free/test, load result
        logic scan_next;  // read the next map word of a find
        logic scan_load;  // load the find result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // clearing pass on its last word
        logic req_find;   // offered request is a find
        logic out_free;   // result register can take a result this cycle
        logic scan_end;   // word under test is the last in range
        logic hit;        // word under test holds a free block
    } status_t;

endpackage

// ===== hw/rtl/bba_req_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: operation and block index with valid/ready.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::OP_W-1:0]   operation;
    logic [bba_pkg::IDX_W-1:0]  block_index;

    modport source (output valid, output operation, output block_index, input ready);
    modport sink   (input valid, input operation, input block_index, output ready);
endinterface

// ===== hw/rtl/bba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bba_rsp_if
// Result channel: busy, found and free block with valid/ready.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       busy_res;
    logic                       found;
    logic [bba_pkg::IDX_W-1:0]  free_block;

    modport source (output valid, output busy_res, output found, output free_block,
                    input ready);
    modport sink   (input valid, input busy_res, input found, input free_block,
                    output ready);
endinterface

// ===== hw/rtl/block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit allocator over a used/free bitmap of storage blocks.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives exactly one result. The map sits
// in a RAM of 32-bit words (block i is bit i mod 32 of word i / 32). After
// reset a clearing pass writes every word, with block 0 marked used; no
// request is taken during it (block_count writes are). Occupy, free and test
// take a RAM read and then a read-modify-write step that loads the result;
// that step waits until the output register is free. Find reads one word per
// cycle and priority-encodes the lowest clear bit below block_count; it stops
// at the first word with a free bit, or at the last word in range. The next
// request is taken in the cycle after a result is loaded, while that result
// may still wait in the output register; the result after it waits for that
// register to empty, and the input stalls for as long.
// ----------------------------------------------------------------------------
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::CNT_W-1:0]   cfg_wr_data,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp
);

    bba_pkg::cmd_t    cmd;
    bba_pkg::status_t status;
    logic             req_ready;

    // controller: clearing pass, intake, lookup and scan sequencing
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: map RAM, count register, scan encoder, result register
    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_operation   (req.operation),
        .req_block_index (req.block_index),
        .cmd             (cmd),
        .status          (status),
        .rsp             (rsp)
    );

    assign req.ready = req_ready;

    // no request transfer while the clearing pass runs
    a_no_take_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !req_ready
    ) else $error("request taken during clearing pass");

    // one request at a time: after a transfer in the block is busy
    a_busy_after_take: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready) |=> !req_ready
    ) else $error("second request taken while one is in progress");

    // a result is loaded only into a free output slot
    a_load_into_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.scan_load) |-> status.out_free
    ) else $error("result loaded over a waiting result");

    // the scan moves on only past words with no free block
    a_scan_past_miss: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.scan_next |-> (!status.hit && !status.scan_end)
    ) else $error("scan advanced past a hit or the last word");

endmodule

// ===== hw/rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, request intake, lookup and find scan.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  bba_pkg::status_t status,
    output bba_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;
    localparam logic [1:0] S_SCAN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = status.req_find ? S_SCAN : S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (status.hit || status.scan_end)
                begin
                    // hold the read word until the result slot frees
                    if (status.out_free)
                    begin
                        cmd.scan_load = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: bitmap RAM, block count, request capture, word scan and
// result register.
// ----------------------------------------------------------------------------
module bba_dp #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic [bba_pkg::OP_W-1:0]    req_operation,
    input  logic [bba_pkg::IDX_W-1:0]   req_block_index,
    input  bba_pkg::cmd_t               cmd,
    output bba_pkg::status_t            status,
    bba_rsp_if.source                   rsp
);

    localparam int WW    = bba_pkg::WORD_W;
    localparam int SH    = bba_pkg::WORD_SH;
    localparam int IW    = bba_pkg::IDX_W;
    localparam int CW    = bba_pkg::CNT_W;
    localparam int WORDS = (MAX_BLOCKS + WW - 1) / WW;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MW    = $clog2(MAX_BLOCKS + 1);
    localparam int LW    = (MW > CW) ? MW : CW;

    logic [CW-1:0]              block_count_reg;
    logic [bba_pkg::OP_W-1:0]   op_reg;
    logic [IW-1:0]              idx_reg;
    logic [AW-1:0]              chk_reg;
    logic [AW-1:0]              clr_reg;
    logic                       rsp_valid_reg;
    logic                       busy_reg;
    logic                       found_reg;
    logic [IW-1:0]              free_block_reg;

    logic [LW-1:0]      bc_ext;
    logic [LW-1:0]      live_cnt;
    logic [LW-1:0]      full_words;
    logic [LW-1:0]      last_word;
    logic [LW-1:0]      chk_ext;
    logic               cnt_empty;
    logic               in_range;
    logic [AW+IW-1:0]   req_idx_wide;
    logic [AW+IW-1:0]   idx_wide;
    logic [AW-1:0]      req_word;
    logic [AW-1:0]      idx_word;
    logic [WW-1:0]      bit_mask;
    logic [WW-1:0]      tail_mask;
    logic [WW-1:0]      range_mask;
    logic [WW-1:0]      free_bits;
    logic [SH-1:0]      enc;
    logic [IW+AW+SH-1:0] pos_ext;
    logic               wr_ok;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WW-1:0]      ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [WW-1:0]      ram_rdata;

    bba_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective count saturates at the map size
    assign bc_ext     = LW'(block_count_reg);
    assign live_cnt   = (bc_ext > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : bc_ext;
    assign cnt_empty  = (live_cnt == '0);
    assign full_words = live_cnt >> SH;
    assign last_word  = full_words - LW'((live_cnt[SH-1:0] == '0) ? 1 : 0);
    assign chk_ext    = LW'(chk_reg);

    assign req_idx_wide = {{AW{1'b0}}, req_block_index};
    assign idx_wide     = {{AW{1'b0}}, idx_reg};
    assign req_word     = req_idx_wide[AW+SH-1:SH];
    assign idx_word     = idx_wide[AW+SH-1:SH];
    assign in_range     = (LW'(idx_reg) < live_cnt);
    assign bit_mask     = WW'(1) << idx_reg[SH-1:0];

    // bits of the word under test that lie below the count
    assign tail_mask  = (WW'(1) << live_cnt[SH-1:0]) - WW'(1);
    assign range_mask = (chk_ext < full_words)  ? '1 :
                        (chk_ext == full_words) ? tail_mask : '0;
    assign free_bits  = ~ram_rdata & range_mask;

    always_comb
    begin
        enc = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                enc = SH'(i);
            end
        end
    end

    assign pos_ext = {{IW{1'b0}}, chk_reg, enc};

    // block 0 is reserved: a free of it never writes
    assign wr_ok = in_range &&
                   ((op_reg == bba_pkg::OP_OCCUPY) ||
                    ((op_reg == bba_pkg::OP_FREE) && (idx_reg != '0)));

    always_comb
    begin
        ram_we    = cmd.clr_step || (cmd.commit && wr_ok);
        ram_waddr = cmd.clr_step ? clr_reg : idx_word;
        if (cmd.clr_step)
        begin
            ram_wdata = (clr_reg == '0) ? WW'(1) : '0;
        end
        else if (op_reg == bba_pkg::OP_OCCUPY)
        begin
            ram_wdata = ram_rdata | bit_mask;
        end
        else
        begin
            ram_wdata = ram_rdata & ~bit_mask;
        end
        ram_re = cmd.take || cmd.scan_next;
        if (cmd.take)
        begin
            ram_raddr = (req_operation == bba_pkg::OP_FIND) ? '0 : req_word;
        end
        else
        begin
            ram_raddr = chk_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= bba_pkg::BLOCK_COUNT_RST;
            clr_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                block_count_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.commit || cmd.scan_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= req_operation;
            idx_reg <= req_block_index;
            chk_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            chk_reg <= chk_reg + AW'(1);
        end
        if (cmd.commit)
        begin
            busy_reg       <= (op_reg == bba_pkg::OP_TEST) &&
                              (!in_range || ((ram_rdata & bit_mask) != '0));
            found_reg      <= 1'b0;
            free_block_reg <= '0;
        end
        else if (cmd.scan_load)
        begin
            busy_reg       <= 1'b0;
            found_reg      <= |free_bits;
            free_block_reg <= (|free_bits) ? pos_ext[IW-1:0] : '0;
        end
    end

    assign status.clr_last = (clr_reg == AW'(WORDS - 1));
    assign status.req_find = (req_operation == bba_pkg::OP_FIND);
    assign status.out_free = !rsp_valid_reg || rsp.ready;
    assign status.scan_end = cnt_empty || (chk_ext == last_word);
    assign status.hit      = |free_bits;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.busy_res   = busy_reg;
    assign rsp.found      = found_reg;
    assign rsp.free_block = free_block_reg;

endmodule
